// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property templates for the checker module of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bdq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bdq assertion failed");

`endif

// ===== rtl/core/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Types, field widths and codes shared by the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 6;

	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_LIST_FWD   = 3'd4;
	localparam logic [OP_W-1:0] OP_LIST_BWD   = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		RES_ELEM,
		RES_ECHO,
		RES_FULL,
		RES_EMPTY,
		RES_DRAINED
	} res_kind_t;

	typedef struct packed {
		logic      in_ready;
		logic      push_back;
		logic      push_front;
		logic      pop_front;
		logic      pop_back;
		logic      rd_start;
		logic      rd_next;
		logic      fwd;
		logic      load;
		res_kind_t kind;
	} bdq_cmd_t;

	typedef struct packed {
		logic            accept;
		logic [OP_W-1:0] op;
		logic            empty;
		logic            full;
		logic            one;
		logic            k_last;
		logic            out_free;
	} bdq_stat_t;

endpackage

// ===== rtl/core/bdq_if.sv =====
// ----------------------------------------------------------------------------
// bdq_if
// Valid/ready channels that carry requests into and results out of the deque.
// ----------------------------------------------------------------------------
interface bdq_in_if import bdq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface bdq_out_if import bdq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] element;
	logic                     has_element;
	logic [STATUS_W-1:0]      status;
	logic                     last;
	logic [OCC_W-1:0]         occupancy;

	modport source (output valid, output element, output has_element, output status,
		output last, output occupancy, input ready);
	modport sink (input valid, input element, input has_element, input status,
		input last, input occupancy, output ready);
endinterface

// ===== rtl/core/bounded_deque_with_readout.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_readout
// Bounded double-ended queue of signed 32-bit values with list readout.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH values in a single-port ring memory. A push
// request passes through the update and single-result states before the next
// acceptance and gives one result. A pop or list request that reads out n
// elements first updates the pointers, then reads the first element, then
// gives one element per cycle when results are taken at once, paced by the
// memory read port and the result register. A stalled result stream holds
// the readout without losing an element. Op codes 6 and 7 pass through the
// update state only and give no result.
module bounded_deque_with_readout import bdq_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	bdq_in_if.sink    req,
	bdq_out_if.source rsp
);

	bdq_cmd_t  ctl;
	bdq_stat_t stat;

	bdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	bdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.ctl    (ctl),
		.stat   (stat)
	);

endmodule

// ===== rtl/core/bdq_dp.sv =====
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath: ring store, front pointer, element count, readout index and the
// result register.
// ----------------------------------------------------------------------------
module bdq_dp import bdq_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	bdq_in_if.sink    req,
	bdq_out_if.source rsp,
	input  bdq_cmd_t  ctl,
	output bdq_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 2;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	logic [AW-1:0]              front_q;
	logic [CW-1:0]              count_q;
	logic [AW-1:0]              k_q;
	logic                       dir_q;
	logic [OP_W-1:0]            op_q;
	logic signed [DATA_W-1:0]   value_q;
	logic signed [DATA_W-1:0]   mem_q [DEPTH];
	logic signed [DATA_W-1:0]   rd_data_q;
	logic                       out_valid_q;
	logic signed [DATA_W-1:0]   out_element_q;
	logic                       out_has_q;
	logic [STATUS_W-1:0]        out_status_q;
	logic                       out_last_q;
	logic [OCC_W-1:0]           out_occ_q;

	logic                       accept;
	logic                       out_free;
	logic                       k_last;
	logic [AW-1:0]              front_dec;
	logic [AW-1:0]              front_inc;
	logic [AW-1:0]              back_addr;
	logic [AW-1:0]              wr_addr;
	logic                       wr_en;
	logic [AW-1:0]              k_use;
	logic                       dir_use;
	logic [CW-1:0]              rd_off;
	logic [AW-1:0]              rd_addr;
	logic                       rd_en;

	function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(off);
		if (s >= DEPTH_S) begin
			s = s - DEPTH_S;
		end
		return s[AW-1:0];
	endfunction

	assign accept   = req.valid && ctl.in_ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign k_last   = (CW'(k_q) == (count_q - CW'(1)));

	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
	assign front_inc = ring_add(front_q, CW'(1));
	assign back_addr = ring_add(front_q, count_q);
	assign wr_addr   = ctl.push_front ? front_dec : back_addr;
	assign wr_en     = ctl.push_back || ctl.push_front;

	assign k_use   = ctl.rd_start ? '0 : k_q + AW'(1);
	assign dir_use = ctl.rd_start ? ctl.fwd : dir_q;
	assign rd_off  = dir_use ? CW'(k_use) : count_q - CW'(1) - CW'(k_use);
	assign rd_addr = ring_add(front_q, rd_off);
	assign rd_en   = ctl.rd_start || ctl.rd_next;

	assign req.ready = ctl.in_ready;

	assign stat.accept   = accept;
	assign stat.op       = op_q;
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == DEPTH_C);
	assign stat.one      = (count_q == CW'(1));
	assign stat.k_last   = k_last;
	assign stat.out_free = out_free;

	assign rsp.valid       = out_valid_q;
	assign rsp.element     = out_element_q;
	assign rsp.has_element = out_has_q;
	assign rsp.status      = out_status_q;
	assign rsp.last        = out_last_q;
	assign rsp.occupancy   = out_occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			k_q         <= '0;
			dir_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.push_back) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.push_front) begin
				front_q <= front_dec;
				count_q <= count_q + CW'(1);
			end else if (ctl.pop_front || ctl.pop_back) begin
				count_q <= count_q - CW'(1);
				if (count_q == CW'(1)) begin
					front_q <= '0;
				end else if (ctl.pop_front) begin
					front_q <= front_inc;
				end
			end
			if (rd_en) begin
				k_q   <= k_use;
				dir_q <= dir_use;
			end
			if (ctl.load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.op;
			value_q <= req.value;
		end
		if (wr_en) begin
			mem_q[wr_addr] <= value_q;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
		if (ctl.load) begin
			out_occ_q <= OCC_W'(count_q);
			case (ctl.kind)
				RES_ELEM: begin
					out_element_q <= rd_data_q;
					out_has_q     <= 1'b1;
					out_status_q  <= ST_OK;
					out_last_q    <= k_last;
				end
				RES_ECHO: begin
					out_element_q <= value_q;
					out_has_q     <= 1'b1;
					out_status_q  <= ST_OK;
					out_last_q    <= 1'b1;
				end
				RES_FULL: begin
					out_element_q <= '0;
					out_has_q     <= 1'b0;
					out_status_q  <= ST_FULL;
					out_last_q    <= 1'b1;
				end
				RES_EMPTY: begin
					out_element_q <= '0;
					out_has_q     <= 1'b0;
					out_status_q  <= ST_EMPTY;
					out_last_q    <= 1'b1;
				end
				default: begin
					out_element_q <= '0;
					out_has_q     <= 1'b0;
					out_status_q  <= ST_OK;
					out_last_q    <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Controller: sequences one request through update, readout and result.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  bdq_stat_t stat,
	output bdq_cmd_t  ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_START,
		S_STREAM,
		S_SINGLE
	} state_t;

	state_t    state_q;
	res_kind_t kind_q;

	always_comb begin
		ctl      = '0;
		ctl.kind = RES_ELEM;
		case (state_q)
			S_IDLE: begin
				ctl.in_ready = 1'b1;
			end
			S_EXEC: begin
				case (stat.op)
					OP_PUSH_BACK:  ctl.push_back  = !stat.full;
					OP_PUSH_FRONT: ctl.push_front = !stat.full;
					OP_POP_FRONT:  ctl.pop_front  = !stat.empty;
					OP_POP_BACK:   ctl.pop_back   = !stat.empty;
					default: begin
					end
				endcase
			end
			S_START: begin
				ctl.rd_start = 1'b1;
				ctl.fwd      = (stat.op != OP_LIST_BWD);
			end
			S_STREAM: begin
				ctl.load    = stat.out_free;
				ctl.rd_next = stat.out_free && !stat.k_last;
			end
			S_SINGLE: begin
				ctl.load = stat.out_free;
				ctl.kind = kind_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= RES_EMPTY;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (stat.accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (stat.op)
						OP_PUSH_BACK, OP_PUSH_FRONT: begin
							kind_q  <= stat.full ? RES_FULL : RES_ECHO;
							state_q <= S_SINGLE;
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (stat.empty) begin
								kind_q  <= RES_EMPTY;
								state_q <= S_SINGLE;
							end else if (stat.one) begin
								kind_q  <= RES_DRAINED;
								state_q <= S_SINGLE;
							end else begin
								state_q <= S_START;
							end
						end
						OP_LIST_FWD, OP_LIST_BWD: begin
							if (stat.empty) begin
								kind_q  <= RES_EMPTY;
								state_q <= S_SINGLE;
							end else begin
								state_q <= S_START;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_START: begin
					state_q <= S_STREAM;
				end
				S_STREAM: begin
					if (stat.out_free && stat.k_last) begin
						state_q <= S_IDLE;
					end
				end
				S_SINGLE: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/bdq_chk.sv =====
// ----------------------------------------------------------------------------
// bdq_chk
// Port-level checker for the bounded deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdq_chk import bdq_pkg::*; #(
	parameter int DEPTH = 32
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic signed [DATA_W-1:0] rsp_element,
	input logic                     rsp_has_element,
	input logic [STATUS_W-1:0]      rsp_status,
	input logic                     rsp_last,
	input logic [OCC_W-1:0]         rsp_occupancy
);

	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

	`BDQ_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_element) && $stable(rsp_last) && $stable(rsp_status))
	`BDQ_ASSERT_IMP(a_no_elem_zero, clk, arst_n, rsp_valid && !rsp_has_element, rsp_element == '0)
	`BDQ_ASSERT_IMP(a_err_single, clk, arst_n, rsp_valid && rsp_status != ST_OK, rsp_last && !rsp_has_element)
	`BDQ_ASSERT_IMP(a_full_occ, clk, arst_n, rsp_valid && rsp_status == ST_FULL, rsp_occupancy == FULL_OCC)

endmodule

bind bounded_deque_with_readout bdq_chk #(
	.DEPTH (DEPTH)
) u_bdq_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_element     (rsp.element),
	.rsp_has_element (rsp.has_element),
	.rsp_status      (rsp.status),
	.rsp_last        (rsp.last),
	.rsp_occupancy   (rsp.occupancy)
);

// ===== verif/tb_bounded_deque_with_readout.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_readout
// Self-checking testbench for the bounded deque with list readout.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the ring store and, for every accepted
// request, queues the results the deque must return. Requests start with a
// directed set of edge cases and continue with random fill, drain and mixed
// episodes. Both channels idle at random, and the result side holds off once
// for a long stretch so that the deque backs up onto its request channel.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_readout;
	import bdq_pkg::*;

	localparam int DEPTH          = 32;
	localparam int CYCLE_LIMIT    = 2_000_000;
	localparam int PRESSURE_HOLD  = 300;
	localparam int ITEM_TARGET    = 195;
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	typedef struct {
		logic signed [DATA_W-1:0] element;
		logic                     has_element;
		logic [STATUS_W-1:0]      status;
		logic                     last;
		logic [OCC_W-1:0]         occupancy;
	} deque_result_t;

	class deque_scoreboard;
		logic signed [DATA_W-1:0] slots [DEPTH];
		int unsigned head;
		int unsigned count;
		deque_result_t awaited_results[$];
		int error_count;

		function void add_result(logic signed [DATA_W-1:0] element, logic has_element,
			logic [STATUS_W-1:0] status, logic last);
			deque_result_t r;
			r.element     = element;
			r.has_element = has_element;
			r.status      = status;
			r.last        = last;
			r.occupancy   = OCC_W'(count);
			awaited_results.push_back(r);
		endfunction

		function void add_readout(bit forward, logic [STATUS_W-1:0] empty_status);
			int unsigned off;
			if (count == 0) begin
				add_result('0, 1'b0, empty_status, 1'b1);
				return;
			end
			for (int unsigned k = 0; k < count; k++) begin
				off = forward ? k : count - 1 - k;
				add_result(slots[(head + off) % DEPTH], 1'b1, ST_OK, k + 1 == count);
			end
		endfunction

		function void apply_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
			case (op)
				OP_PUSH_BACK, OP_PUSH_FRONT: begin
					if (count >= DEPTH) begin
						add_result('0, 1'b0, ST_FULL, 1'b1);
					end else begin
						if (op == OP_PUSH_BACK) begin
							slots[(head + count) % DEPTH] = value;
						end else begin
							head = (head + DEPTH - 1) % DEPTH;
							slots[head] = value;
						end
						count++;
						add_result(value, 1'b1, ST_OK, 1'b1);
					end
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					if (count == 0) begin
						add_result('0, 1'b0, ST_EMPTY, 1'b1);
					end else begin
						if (op == OP_POP_FRONT)
							head = (head + 1) % DEPTH;
						count--;
						if (count == 0)
							head = 0;
						add_readout(1'b1, ST_OK);
					end
				end
				OP_LIST_FWD: add_readout(1'b1, ST_EMPTY);
				OP_LIST_BWD: add_readout(1'b0, ST_EMPTY);
				default: ;
			endcase
		endfunction

		function void check_result(logic signed [DATA_W-1:0] element, logic has_element,
			logic [STATUS_W-1:0] status, logic last, logic [OCC_W-1:0] occupancy);
			deque_result_t e;
			if (awaited_results.size() == 0) begin
				$error("unexpected result: element %0d status %0d occupancy %0d",
					element, status, occupancy);
				error_count++;
				return;
			end
			e = awaited_results.pop_front();
			if (element !== e.element) begin
				$error("element: expected %0d, got %0d", e.element, element);
				error_count++;
			end
			if (has_element !== e.has_element) begin
				$error("has_element: expected %0b, got %0b", e.has_element, has_element);
				error_count++;
			end
			if (status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, status);
				error_count++;
			end
			if (last !== e.last) begin
				$error("last: expected %0b, got %0b", e.last, last);
				error_count++;
			end
			if (occupancy !== e.occupancy) begin
				$error("occupancy: expected %0d, got %0d", e.occupancy, occupancy);
				error_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bdq_in_if  req ();
	bdq_out_if rsp ();

	deque_scoreboard sb;
	bit pressure_go;
	int items_sent;
	int sender_calm;
	int cycles;

	bounded_deque_with_readout #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30) return OP_PUSH_BACK;
		if (r < 55) return OP_PUSH_FRONT;
		if (r < 68) return OP_POP_FRONT;
		if (r < 80) return OP_POP_BACK;
		if (r < 88) return OP_LIST_FWD;
		if (r < 96) return OP_LIST_BWD;
		return ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
	endfunction

	task automatic issue(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
		int unsigned gap;
		gap = 0;
		if (sender_calm > 0)
			sender_calm--;
		else if ($urandom_range(0, 29) == 0)
			sender_calm = $urandom_range(20, 60);
		else if ($urandom_range(0, 1) != 0)
			gap = idle_len();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.op    <= op;
		req.value <= value;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.apply_request(op, value);
		if (op <= OP_LIST_BWD)
			items_sent++;
	endtask

	task automatic fill_up(input int extra);
		while (sb.count < DEPTH)
			issue(($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
		repeat (extra)
			issue(($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
	endtask

	task automatic drain_out();
		while (sb.count > 0)
			issue(($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
		issue(($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
	endtask

	// Request side and run control.
	initial begin
		int unsigned r;
		sb = new();
		pressure_go = 1'b0;
		items_sent  = 0;
		sender_calm = 0;
		arst_n    <= 1'b0;
		req.valid <= 1'b0;
		req.op    <= OP_PUSH_BACK;
		req.value <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(OP_LIST_FWD, $urandom);
		issue(OP_LIST_BWD, $urandom);
		issue(OP_POP_FRONT, $urandom);
		issue(OP_POP_BACK, $urandom);
		issue(OP_SPARE_A, $urandom);
		issue(OP_SPARE_B, $urandom);
		issue(OP_PUSH_BACK, 32'sh7fffffff);
		issue(OP_POP_BACK, $urandom);
		issue(OP_PUSH_FRONT, 32'sh80000000);
		issue(OP_POP_FRONT, $urandom);
		issue(OP_PUSH_FRONT, '0);
		issue(OP_PUSH_BACK, -1);
		issue(OP_PUSH_FRONT, 32'sh55555555);
		issue(OP_PUSH_BACK, 32'shaaaaaaaa);
		issue(OP_LIST_FWD, $urandom);
		issue(OP_LIST_BWD, $urandom);
		issue(OP_POP_FRONT, $urandom);
		issue(OP_POP_BACK, $urandom);
		issue(OP_LIST_FWD, $urandom);
		issue(OP_POP_FRONT, $urandom);
		issue(OP_POP_BACK, $urandom);

		// The first fill runs into the long hold-off on the result side.
		pressure_go = 1'b1;
		fill_up(3);
		issue(OP_LIST_FWD, $urandom);
		issue(OP_LIST_BWD, $urandom);
		drain_out();

		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 12)
				fill_up($urandom_range(0, 2));
			else if (r < 24)
				drain_out();
			else
				repeat ($urandom_range(8, 20)) issue(pick_op(), pick_value());
		end
		req.valid <= 1'b0;

		while (sb.awaited_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.awaited_results.size() != 0) begin
			$error("%0d results never arrived", sb.awaited_results.size());
			sb.error_count++;
		end
		if (sb.error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Result side: random stalls, calm stretches and one long hold-off.
	initial begin
		int stall_left;
		int calm_left;
		bit pressure_used;
		stall_left    = 0;
		calm_left     = 0;
		pressure_used = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pressure_go && !pressure_used) begin
				pressure_used = 1'b1;
				stall_left    = PRESSURE_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 39) == 0)
					calm_left = $urandom_range(40, 150);
				else if ($urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result(rsp.element, rsp.has_element, rsp.status, rsp.last,
				rsp.occupancy);
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bdq_pkg.sv
rtl/core/bdq_if.sv
rtl/core/bdq_dp.sv
rtl/core/bdq_ctrl.sv
rtl/core/bounded_deque_with_readout.sv
rtl/core/bdq_chk.sv
verif/tb_bounded_deque_with_readout.sv
